// File: sv/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock, masked during reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// concurrent check that also runs while reset is low
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/rse_pkg.sv
package rse_pkg;

  localparam int unsigned XLEN      = 64;
  localparam int unsigned REG_COUNT = 32;
  localparam int unsigned RA_W      = 5;
  localparam int unsigned CFG_COUNT = 7;

  // register indexes of the architectural registers loaded on start
  localparam logic [RA_W-1:0] REG_RA = 5'd1;
  localparam logic [RA_W-1:0] REG_SP = 5'd2;
  localparam logic [RA_W-1:0] REG_A0 = 5'd10;
  localparam logic [RA_W-1:0] REG_A1 = 5'd11;
  localparam logic [RA_W-1:0] REG_A2 = 5'd12;
  localparam logic [RA_W-1:0] REG_A3 = 5'd13;

  // configuration register indexes
  localparam logic [2:0] CFG_START_PC  = 3'd0;
  localparam logic [2:0] CFG_STOP_PC   = 3'd1;
  localparam logic [2:0] CFG_STACK_TOP = 3'd2;
  localparam logic [2:0] CFG_ARG0      = 3'd3;
  localparam logic [2:0] CFG_ARG1      = 3'd4;
  localparam logic [2:0] CFG_ARG2      = 3'd5;
  localparam logic [2:0] CFG_ARG3      = 3'd6;

  // opcodes and function codes
  localparam logic [6:0] OPC_OP     = 7'b0110011;
  localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_OP32   = 7'b0111011;
  localparam logic [6:0] F7_BASE    = 7'b0000000;
  localparam logic [6:0] F7_ALT     = 7'b0100000;
  localparam logic [6:0] F7_MUL     = 7'b0000001;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_AND  = 3'd7;
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BYTE = 3'd0;
  localparam logic [2:0] F3_WORD = 3'd2;
  localparam logic [2:0] F3_DBL  = 3'd3;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_EXEC  = 2'd1,
    ACT_LRET  = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    MOP_NONE  = 2'd0,
    MOP_READ  = 2'd1,
    MOP_WRITE = 2'd2
  } mem_op_t;

  typedef enum logic [1:0] {
    MSZ_BYTE = 2'd0,
    MSZ_WORD = 2'd1,
    MSZ_DBL  = 2'd2
  } mem_size_t;

  typedef enum logic [1:0] {
    FLT_NONE   = 2'd0,
    FLT_OPCODE = 2'd1,
    FLT_FUNCT  = 2'd2
  } fault_t;

  typedef enum logic [2:0] {
    CLS_ALU    = 3'd0,
    CLS_LOAD   = 3'd1,
    CLS_STORE  = 3'd2,
    CLS_JUMP   = 3'd3,
    CLS_BTAKEN = 3'd4,
    CLS_BNOT   = 3'd5,
    CLS_NONE   = 3'd6
  } iclass_t;

  // result beat fields except the register value
  typedef struct packed {
    logic [XLEN-1:0] next_pc;
    logic            halted;
    mem_op_t         mem_op;
    logic [XLEN-1:0] mem_addr;
    mem_size_t       mem_size;
    logic [XLEN-1:0] store_data;
    fault_t          fault;
    iclass_t         instr_class;
  } exec_res_t;

  // register file write request
  typedef struct packed {
    logic            en;
    logic            start;
    logic [RA_W-1:0] addr;
    logic [XLEN-1:0] data;
  } rf_wr_t;

  // control state update from one beat
  typedef struct packed {
    logic [XLEN-1:0] pc;
    logic            stopped;
    logic            pend;
    logic [RA_W-1:0] pdest;
    mem_size_t       psize;
  } ctl_upd_t;

endpackage

// File: sv/rse_regfile.sv
module rse_regfile
  import rse_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  rf_wr_t          wr,
  input  logic            wr_go,
  input  logic [XLEN-1:0] stop_pc,
  input  logic [XLEN-1:0] stack_top,
  input  logic [XLEN-1:0] arg0,
  input  logic [XLEN-1:0] arg1,
  input  logic [XLEN-1:0] arg2,
  input  logic [XLEN-1:0] arg3,
  input  logic [RA_W-1:0] rd_addr1,
  input  logic [RA_W-1:0] rd_addr2,
  output logic [XLEN-1:0] rd_data1,
  output logic [XLEN-1:0] rd_data2,
  output logic [XLEN-1:0] a0_nxt
);

  logic [XLEN-1:0] rf_r   [REG_COUNT];
  logic [XLEN-1:0] rf_nxt [REG_COUNT];

  // contents after this cycle's write, x0 pinned to zero
  always_comb begin
    for (int i = 0; i < REG_COUNT; i++) begin
      rf_nxt[i] = rf_r[i];
    end
    if (wr_go && wr.start) begin
      rf_nxt[REG_RA] = stop_pc;
      rf_nxt[REG_SP] = stack_top;
      rf_nxt[REG_A0] = arg0;
      rf_nxt[REG_A1] = arg1;
      rf_nxt[REG_A2] = arg2;
      rf_nxt[REG_A3] = arg3;
    end
    if (wr_go && wr.en) begin
      rf_nxt[wr.addr] = wr.data;
    end
    rf_nxt[0] = '0;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < REG_COUNT; i++) begin
      if (!rst_n) begin
        rf_r[i] <= '0;
      end else begin
        rf_r[i] <= rf_nxt[i];
      end
    end
  end

  // operand reads see the write of the beat retiring this cycle
  assign rd_data1 = rf_nxt[rd_addr1];
  assign rd_data2 = rf_nxt[rd_addr2];
  assign a0_nxt   = rf_nxt[REG_A0];

endmodule

// File: sv/rse_exec.sv
module rse_exec
  import rse_pkg::*;
(
  input  action_t         action,
  input  logic [31:0]     iw,
  input  logic [XLEN-1:0] load_value,
  input  logic [XLEN-1:0] op_a,
  input  logic [XLEN-1:0] op_b,
  input  logic [XLEN-1:0] mul_prod,
  input  logic [XLEN-1:0] start_pc,
  input  logic [XLEN-1:0] stop_pc,
  input  ctl_upd_t        ctl,
  output logic            is_mul,
  output exec_res_t       res,
  output ctl_upd_t        ctl_nxt,
  output rf_wr_t          wr
);

  logic [6:0]      opc;
  logic [RA_W-1:0] rd;
  logic [2:0]      f3;
  logic [6:0]      f7;
  logic [5:0]      f6;
  logic [5:0]      shi;
  logic [XLEN-1:0] immi;
  logic [XLEN-1:0] imms;
  logic [XLEN-1:0] immb;
  logic [XLEN-1:0] immj;
  logic [XLEN-1:0] npc;
  logic [XLEN-1:0] alu;
  logic [XLEN-1:0] a_w;
  logic [31:0]     sllw;
  logic            live;
  logic            wr_alu;
  logic            taken;
  fault_t          flt;
  mem_size_t       msz;
  exec_res_t       dres;

  // instruction fields and immediates
  assign opc  = iw[6:0];
  assign rd   = iw[11:7];
  assign f3   = iw[14:12];
  assign f7   = iw[31:25];
  assign f6   = iw[31:26];
  assign shi  = iw[25:20];
  assign immi = {{(XLEN-12){iw[31]}}, iw[31:20]};
  assign imms = {{(XLEN-12){iw[31]}}, iw[31:25], iw[11:7]};
  assign immb = {{(XLEN-13){iw[31]}}, iw[31], iw[7], iw[30:25], iw[11:8], 1'b0};
  assign immj = {{(XLEN-21){iw[31]}}, iw[31], iw[19:12], iw[20], iw[30:21], 1'b0};
  assign a_w  = {{(XLEN-32){op_a[31]}}, op_a[31:0]};
  assign sllw = op_a[31:0] << op_b[4:0];

  assign live   = (action == ACT_EXEC) && !ctl.stopped && !ctl.pend;
  assign is_mul = live && (opc == OPC_OP) && (f3 == F3_ADD) && (f7 == F7_MUL);

  // access size from funct3
  always_comb begin
    case (f3)
      F3_BYTE: msz = MSZ_BYTE;
      F3_WORD: msz = MSZ_WORD;
      default: msz = MSZ_DBL;
    endcase
  end

  // decode and execute one instruction
  always_comb begin
    dres             = '0;
    dres.instr_class = CLS_NONE;
    dres.mem_op      = MOP_NONE;
    dres.mem_size    = MSZ_BYTE;
    dres.fault       = FLT_NONE;
    flt              = FLT_NONE;
    alu              = '0;
    wr_alu           = 1'b0;
    taken            = 1'b0;
    npc              = ctl.pc + XLEN'(4);
    case (opc)
      OPC_OP: begin
        dres.instr_class = CLS_ALU;
        wr_alu           = 1'b1;
        if (f3 == F3_ADD && f7 == F7_BASE) begin
          alu = op_a + op_b;
        end else if (f3 == F3_ADD && f7 == F7_ALT) begin
          alu = op_a - op_b;
        end else if (f3 == F3_ADD && f7 == F7_MUL) begin
          alu = mul_prod;
        end else if (f3 == F3_SLL && f7 == F7_BASE) begin
          alu = op_a << op_b[5:0];
        end else if (f3 == F3_SR && f7 == F7_BASE) begin
          alu = op_a >> op_b[5:0];
        end else if (f3 == F3_SR && f7 == F7_ALT) begin
          alu = XLEN'($signed(op_a) >>> op_b[5:0]);
        end else if (f3 == F3_AND && f7 == F7_BASE) begin
          alu = op_a & op_b;
        end else begin
          flt = FLT_FUNCT;
        end
      end
      OPC_OPIMM: begin
        dres.instr_class = CLS_ALU;
        wr_alu           = 1'b1;
        if (f3 == F3_ADD) begin
          alu = op_a + immi;
        end else if (f3 == F3_SLL && f6 == 6'd0) begin
          alu = op_a << shi;
        end else if (f3 == F3_SR && f6 == 6'd0) begin
          alu = op_a >> shi;
        end else begin
          flt = FLT_FUNCT;
        end
      end
      OPC_OP32: begin
        dres.instr_class = CLS_ALU;
        wr_alu           = 1'b1;
        if (f3 == F3_SLL && f7 == F7_BASE) begin
          alu = {{(XLEN-32){sllw[31]}}, sllw};
        end else if (f3 == F3_SR && f7 == F7_ALT) begin
          alu = XLEN'($signed(a_w) >>> op_b[4:0]);
        end else begin
          flt = FLT_FUNCT;
        end
      end
      OPC_BRANCH: begin
        case (f3)
          F3_BEQ:  taken = (op_a == op_b);
          F3_BNE:  taken = (op_a != op_b);
          F3_BLT:  taken = ($signed(op_a) < $signed(op_b));
          F3_BGE:  taken = ($signed(op_a) >= $signed(op_b));
          default: flt = FLT_FUNCT;
        endcase
        if (taken) begin
          npc = ctl.pc + immb;
        end
        dres.instr_class = taken ? CLS_BTAKEN : CLS_BNOT;
      end
      OPC_LOAD: begin
        dres.instr_class = CLS_LOAD;
        if (f3 == F3_BYTE || f3 == F3_WORD || f3 == F3_DBL) begin
          dres.mem_op   = MOP_READ;
          dres.mem_addr = op_a + immi;
          dres.mem_size = msz;
        end else begin
          flt = FLT_FUNCT;
        end
      end
      OPC_STORE: begin
        dres.instr_class = CLS_STORE;
        if (f3 == F3_BYTE || f3 == F3_WORD || f3 == F3_DBL) begin
          dres.mem_op   = MOP_WRITE;
          dres.mem_addr = op_a + imms;
          dres.mem_size = msz;
          case (msz)
            MSZ_BYTE: dres.store_data = {{(XLEN-8){1'b0}}, op_b[7:0]};
            MSZ_WORD: dres.store_data = {{(XLEN-32){1'b0}}, op_b[31:0]};
            default:  dres.store_data = op_b;
          endcase
        end else begin
          flt = FLT_FUNCT;
        end
      end
      OPC_JAL: begin
        dres.instr_class = CLS_JUMP;
        wr_alu           = 1'b1;
        alu              = npc;
        npc              = ctl.pc + immj;
      end
      OPC_JALR: begin
        dres.instr_class = CLS_JUMP;
        if (f3 == 3'd0) begin
          wr_alu = 1'b1;
          alu    = npc;
          npc    = (op_a + immi) & ~XLEN'(1);
        end else begin
          flt = FLT_FUNCT;
        end
      end
      default: begin
        flt = FLT_OPCODE;
      end
    endcase
    // a fault cancels the memory request and the class
    if (flt != FLT_NONE) begin
      dres             = '0;
      dres.instr_class = CLS_NONE;
      dres.mem_op      = MOP_NONE;
      dres.mem_size    = MSZ_BYTE;
      dres.fault       = flt;
    end
    if (!live) begin
      dres             = '0;
      dres.instr_class = CLS_NONE;
      dres.mem_op      = MOP_NONE;
      dres.mem_size    = MSZ_BYTE;
      dres.fault       = FLT_NONE;
    end
  end

  // state update and register write
  always_comb begin
    res      = dres;
    ctl_nxt  = ctl;
    wr       = '0;
    wr.addr  = rd;
    wr.data  = alu;
    case (action)
      ACT_START: begin
        wr.start        = 1'b1;
        ctl_nxt.pc      = start_pc;
        ctl_nxt.pend    = 1'b0;
        ctl_nxt.stopped = (start_pc == stop_pc);
      end
      ACT_LRET: begin
        if (ctl.pend) begin
          wr.en        = 1'b1;
          wr.addr      = ctl.pdest;
          ctl_nxt.pend = 1'b0;
          case (ctl.psize)
            MSZ_BYTE: wr.data = {{(XLEN-8){load_value[7]}}, load_value[7:0]};
            MSZ_WORD: wr.data = {{(XLEN-32){load_value[31]}}, load_value[31:0]};
            default:  wr.data = load_value;
          endcase
        end
      end
      ACT_EXEC: begin
        if (live) begin
          if (dres.fault != FLT_NONE) begin
            ctl_nxt.stopped = 1'b1;
          end else begin
            wr.en      = wr_alu;
            ctl_nxt.pc = npc;
            if (npc == stop_pc) begin
              ctl_nxt.stopped = 1'b1;
            end
            if (dres.mem_op == MOP_READ) begin
              ctl_nxt.pend  = 1'b1;
              ctl_nxt.pdest = rd;
              ctl_nxt.psize = dres.mem_size;
            end
          end
        end
      end
      default: begin
        ctl_nxt = ctl;
      end
    endcase
    res.next_pc = ctl_nxt.pc;
    res.halted  = ctl_nxt.stopped;
  end

endmodule

// File: sv/rv64_subset_execute_core.sv
// path: an accepted input beat is registered in the input stage, then in the result register
// throughput: one beat per cycle unless out_stall holds the result; a mul holds the input stage
//   while the partial products of its 32-bit halves settle in registers
// reset: synchronous active-low; registers, pc and config clear to zero, the run
//   is stopped until a start beat, and both pipeline stages empty
module rv64_subset_execute_core
  import rse_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [63:0]     cfg_wdata,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      in_action,
  input  logic [31:0]     in_instr_word,
  input  logic [63:0]     in_load_value,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [63:0]     out_next_pc,
  output logic            out_halted,
  output logic [1:0]      out_mem_op,
  output logic [63:0]     out_mem_addr,
  output logic [1:0]      out_mem_size,
  output logic [63:0]     out_store_data,
  output logic [1:0]      out_fault,
  output logic [63:0]     out_return_value,
  output logic [2:0]      out_instr_class
);

`include "assert_macros.svh"

  logic [XLEN-1:0] cfg_r [CFG_COUNT];

  logic            q_valid_r;
  action_t         q_action_r;
  logic [31:0]     q_iw_r;
  logic [XLEN-1:0] q_lv_r;
  logic [XLEN-1:0] q_a_r;
  logic [XLEN-1:0] q_b_r;

  logic            mul_phase_r;
  logic [XLEN-1:0] mp0_r;
  logic [31:0]     mp1_r;
  logic [31:0]     mp2_r;
  logic [XLEN-1:0] mul_prod;

  ctl_upd_t        ctl_r;
  ctl_upd_t        ctl_nxt;

  logic            o_valid_r;
  exec_res_t       o_res_r;
  logic [XLEN-1:0] o_a0_r;

  exec_res_t       ex_res;
  rf_wr_t          ex_wr;
  logic            ex_mul;
  logic            advance;
  logic            in_take;
  logic [XLEN-1:0] rd1;
  logic [XLEN-1:0] rd2;
  logic [XLEN-1:0] a0_nxt;

  // configuration registers
  always_ff @(posedge clk) begin
    for (int i = 0; i < CFG_COUNT; i++) begin
      if (!rst_n) begin
        cfg_r[i] <= '0;
      end else if (cfg_we && cfg_index == 3'(i)) begin
        cfg_r[i] <= cfg_wdata;
      end
    end
  end

  // handshake between stages
  assign advance  = q_valid_r && (!o_valid_r || !out_stall) && !(ex_mul && !mul_phase_r);
  assign in_take  = in_valid && !in_stall;
  assign in_stall = q_valid_r && !advance;

  rse_regfile u_rf (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (ex_wr),
    .wr_go     (advance),
    .stop_pc   (cfg_r[CFG_STOP_PC]),
    .stack_top (cfg_r[CFG_STACK_TOP]),
    .arg0      (cfg_r[CFG_ARG0]),
    .arg1      (cfg_r[CFG_ARG1]),
    .arg2      (cfg_r[CFG_ARG2]),
    .arg3      (cfg_r[CFG_ARG3]),
    .rd_addr1  (in_instr_word[19:15]),
    .rd_addr2  (in_instr_word[24:20]),
    .rd_data1  (rd1),
    .rd_data2  (rd2),
    .a0_nxt    (a0_nxt)
  );

  // input stage with operands read on entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r <= 1'b0;
    end else if (in_take) begin
      q_valid_r <= 1'b1;
    end else if (advance) begin
      q_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      q_action_r <= action_t'(in_action);
      q_iw_r     <= in_instr_word;
      q_lv_r     <= in_load_value;
      q_a_r      <= rd1;
      q_b_r      <= rd2;
    end
  end

  // mul partial products, low 64 bits only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_phase_r <= 1'b0;
    end else if (advance) begin
      mul_phase_r <= 1'b0;
    end else if (ex_mul && q_valid_r) begin
      mul_phase_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_mul && !mul_phase_r) begin
      mp0_r <= q_a_r[31:0] * q_b_r[31:0];
      mp1_r <= 32'(q_a_r[31:0] * q_b_r[63:32]);
      mp2_r <= 32'(q_a_r[63:32] * q_b_r[31:0]);
    end
  end

  assign mul_prod = mp0_r + {mp1_r + mp2_r, 32'd0};

  rse_exec u_exec (
    .action     (q_action_r),
    .iw         (q_iw_r),
    .load_value (q_lv_r),
    .op_a       (q_a_r),
    .op_b       (q_b_r),
    .mul_prod   (mul_prod),
    .start_pc   (cfg_r[CFG_START_PC]),
    .stop_pc    (cfg_r[CFG_STOP_PC]),
    .ctl        (ctl_r),
    .is_mul     (ex_mul),
    .res        (ex_res),
    .ctl_nxt    (ctl_nxt),
    .wr         (ex_wr)
  );

  // architectural control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r         <= '0;
      ctl_r.stopped <= 1'b1;
    end else if (advance) begin
      ctl_r <= ctl_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (advance) begin
      o_valid_r <= 1'b1;
    end else if (!out_stall) begin
      o_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_res_r <= ex_res;
      o_a0_r  <= a0_nxt;
    end
  end

  assign out_valid        = o_valid_r;
  assign out_next_pc      = o_res_r.next_pc;
  assign out_halted       = o_res_r.halted;
  assign out_mem_op       = o_res_r.mem_op;
  assign out_mem_addr     = o_res_r.mem_addr;
  assign out_mem_size     = o_res_r.mem_size;
  assign out_store_data   = o_res_r.store_data;
  assign out_fault        = o_res_r.fault;
  assign out_return_value = o_a0_r;
  assign out_instr_class  = o_res_r.instr_class;

  // checks
  `ASSERT_CLK(a_fault_halts, clk, rst_n,
    o_valid_r && o_res_r.fault != FLT_NONE |-> o_res_r.halted, "fault without halt")
  `ASSERT_CLK(a_idle_mem, clk, rst_n,
    o_valid_r && o_res_r.mem_op == MOP_NONE |-> o_res_r.mem_addr == '0, "stray mem address")
  `ASSERT_CLK(a_mul_held, clk, rst_n,
    mul_phase_r |-> q_valid_r && $past(q_valid_r), "mul phase without item")
  `ASSERT_CLK(a_pend_stalls, clk, rst_n,
    advance && ctl_r.pend && q_action_r == ACT_EXEC |-> !ex_wr.en, "exec while load pending")

endmodule
